// ===== src/rgbpwm_pkg.sv =====
`default_nettype none
package rgbpwm_pkg;

	localparam logic [7:0]  CharCr    = 8'h0D;
	localparam logic [7:0]  CharLf    = 8'h0A;
	localparam logic [15:0] CharZero  = 16'd48;
	localparam logic [7:0]  LevelMax  = 8'd255;
	localparam logic [13:0] PwmTop    = 14'd9999;
	localparam logic [13:0] PwmStep   = 14'd39;

	typedef enum logic [1:0] {
		CH_NONE  = 2'd0,
		CH_RED   = 2'd1,
		CH_GREEN = 2'd2,
		CH_BLUE  = 2'd3
	} chan_t;

	typedef struct packed {
		logic        done;
		chan_t       chan;
		logic [7:0]  level;
		logic [13:0] red;
		logic [13:0] green;
		logic [13:0] blue;
	} cmd_result_t;

	// three ASCII digits, 16-bit wrapping, no digit check, clamped to 255
	function automatic logic [7:0] decode_level(input logic [7:0] h, input logic [7:0] t,
			input logic [7:0] u);
		logic [15:0] sum;
		sum = (({8'd0, h} - CharZero) * 16'd100)
			+ (({8'd0, t} - CharZero) * 16'd10)
			+ ({8'd0, u} - CharZero);
		return (sum > {8'd0, LevelMax}) ? LevelMax : sum[7:0];
	endfunction

	// inverted PWM compare: 0 -> top, 255 -> 0, else (top-1) - step*n
	function automatic logic [13:0] level_to_compare(input logic [7:0] n);
		logic [13:0] cmp;
		if (n == 8'd0)
			cmp = PwmTop;
		else if (n == LevelMax)
			cmp = 14'd0;
		else
			cmp = (PwmTop - 14'd1) - (PwmStep * {6'd0, n});
		return cmp;
	endfunction

endpackage
`default_nettype wire

// ===== src/rgbpwm_cmd.sv =====
`default_nettype none
module rgbpwm_cmd (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     step,
	input  wire logic [7:0]               rx_byte,
	output rgbpwm_pkg::cmd_result_t       result
);

	logic [1:0]  pos_q;
	logic [7:0]  letter_q;
	logic [7:0]  hund_q;
	logic [7:0]  tens_q;
	logic [13:0] red_q;
	logic [13:0] green_q;
	logic [13:0] blue_q;

	logic              line_end;
	logic [7:0]        level;
	logic [13:0]       cmp;
	rgbpwm_pkg::chan_t chan;

	assign line_end = (rx_byte == rgbpwm_pkg::CharCr) || (rx_byte == rgbpwm_pkg::CharLf);
	assign level    = rgbpwm_pkg::decode_level(hund_q, tens_q, rx_byte);
	assign cmp      = rgbpwm_pkg::level_to_compare(level);

	always_comb begin
		case (letter_q) inside
			8'h42, 8'h62: chan = rgbpwm_pkg::CH_BLUE;   // B b
			8'h47, 8'h67: chan = rgbpwm_pkg::CH_GREEN;  // G g
			8'h52, 8'h72: chan = rgbpwm_pkg::CH_RED;    // R r
			default:      chan = rgbpwm_pkg::CH_NONE;
		endcase
	end

	// result shows the compare values after this update
	always_comb begin
		result.done  = step && !line_end && (pos_q == 2'd3);
		result.chan  = chan;
		result.level = level;
		result.red   = (chan == rgbpwm_pkg::CH_RED)   ? cmp : red_q;
		result.green = (chan == rgbpwm_pkg::CH_GREEN) ? cmp : green_q;
		result.blue  = (chan == rgbpwm_pkg::CH_BLUE)  ? cmp : blue_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 2'd0;
			letter_q <= 8'd0;
			hund_q   <= 8'd0;
			tens_q   <= 8'd0;
			red_q    <= rgbpwm_pkg::PwmTop;
			green_q  <= rgbpwm_pkg::PwmTop;
			blue_q   <= rgbpwm_pkg::PwmTop;
		end else if (step && !line_end) begin
			pos_q <= pos_q + 2'd1;
			case (pos_q)
				2'd0: letter_q <= rx_byte;
				2'd1: hund_q   <= rx_byte;
				2'd2: tens_q   <= rx_byte;
				default: begin
					red_q   <= result.red;
					green_q <= result.green;
					blue_q  <= result.blue;
				end
			endcase
		end
	end

	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result.done |-> pos_q == 2'd3)
		else $error("command completed away from the units digit");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		result.done |=> pos_q == 2'd0)
		else $error("position did not return to the letter after a command");

	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && line_end |=> $stable(pos_q) && $stable(red_q) && $stable(green_q)
			&& $stable(blue_q))
		else $error("line end byte changed command state");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		red_q <= rgbpwm_pkg::PwmTop && green_q <= rgbpwm_pkg::PwmTop
			&& blue_q <= rgbpwm_pkg::PwmTop)
		else $error("compare value above PWM top");

endmodule
`default_nettype wire

// ===== src/rgb_serial_command_pwm.sv =====
`default_nettype none
// RGB serial command decoder. Each input transaction carries one received byte; CR and LF
// are dropped. Four other bytes form a command (channel letter R/G/B, either case, then
// three ASCII digits); the fourth produces one output transaction with the channel
// updated (0 for an unknown letter), the clamped level and all three inverted PWM compare
// values (9999 = off, 0 = full on). A byte is accepted every cycle unless the input is
// stalled; it is held in the input register, decoded there, and the result of the
// completing byte is then registered into the output register when that register is free.
// Output backpressure stalls the input register, and the input stops only when both the
// input register and the output register are full.
module rgb_serial_command_pwm (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [55:0] m_axis_tdata,   // [7:0] level, [21:8] red_compare,
	                                         // [35:22] green_compare, [49:36] blue_compare
	output      logic [1:0]  m_axis_tuser    // [1:0] channel_updated
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    out_free;
	logic                    step;
	rgbpwm_pkg::cmd_result_t result;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;
	assign step          = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			byte_s1 <= s_axis_tdata;
	end

	rgbpwm_cmd u_cmd (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (out_free)
			m_axis_tvalid <= result.done;
	end

	always_ff @(posedge clk) begin
		if (out_free && result.done) begin
			m_axis_tdata <= {6'd0, result.blue, result.green, result.red, result.level};
			m_axis_tuser <= result.chan;
		end
	end

endmodule
`default_nettype wire
